[src/assert_macros.svh]
// assertion macros shared by the rtl
// depends on nothing; the including module provides i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

[src/rbis_pkg.sv]
// types, microcode table and saturation helpers for the rigid body integrator
// used by rigid_body_integrator_step; depends on nothing
`timescale 1ns / 1ps

package rbis_pkg;

    // item modes
    localparam logic [2:0] MODE_STEP      = 3'd0;
    localparam logic [2:0] MODE_FORCE     = 3'd1;
    localparam logic [2:0] MODE_TORQUE    = 3'd2;
    localparam logic [2:0] MODE_CLR_LIN   = 3'd3;
    localparam logic [2:0] MODE_CLR_ANG   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_X = 3'd0;
    localparam logic [2:0] CFG_MAX_X = 3'd1;
    localparam logic [2:0] CFG_MIN_Y = 3'd2;
    localparam logic [2:0] CFG_MAX_Y = 3'd3;
    localparam logic [2:0] CFG_MIN_Z = 3'd4;
    localparam logic [2:0] CFG_MAX_Z = 3'd5;
    localparam logic [2:0] CFG_IMASS = 3'd6;
    localparam logic [2:0] CFG_IINER = 3'd7;

    // reset values
    localparam logic signed [31:0] BOX_LO_RST = -32'sd655360;
    localparam logic signed [31:0] BOX_HI_RST = 32'sd655360;
    localparam logic [30:0]        INV_RST    = 31'd65536;
    localparam logic signed [31:0] Q_ONE      = 32'sh4000_0000;

    // microcode entry points
    localparam logic [5:0] PC_STEP   = 6'd0;
    localparam logic [5:0] PC_FORCE  = 6'd22;
    localparam logic [5:0] PC_TORQUE = 6'd25;

    // operand and destination codes of the shared multiply-accumulate
    typedef enum logic [4:0] {
        R_ZERO, R_F0, R_F1, R_F2, R_A0, R_A1, R_A2, R_DT, R_IM, R_II,
        R_LM0, R_LM1, R_LM2, R_SM0, R_SM1, R_SM2, R_POS0, R_POS1, R_POS2,
        R_Q0, R_Q1, R_Q2, R_Q3, R_T0, R_T1, R_T2, R_N0, R_N1, R_N2, R_N3, R_NSQ
    } t_reg;

    typedef enum logic [1:0] {SH0, SH16, SH17} t_shift;

    typedef enum logic [1:0] {SAT_32, SAT_SYM, SAT_CLAMP, SAT_NONE} t_sat;

    typedef struct packed {
        t_reg   a;
        t_reg   b;
        t_shift sh;
        logic   tsat;
        logic   load;
        t_reg   base;
        logic   neg;
        logic   wr;
        t_reg   dst;
        t_sat   sat;
        logic   wsh;
        logic   last;
    } t_uop;

    function automatic t_uop mk(t_reg a, t_reg b, t_shift sh, int tsat, int load,
                                t_reg base, int neg, int wr, t_reg dst, t_sat sat,
                                int wsh, int last);
        t_uop u;
        u.a = a; u.b = b; u.sh = sh; u.tsat = tsat[0]; u.load = load[0]; u.base = base;
        u.neg = neg[0]; u.wr = wr[0]; u.dst = dst; u.sat = sat; u.wsh = wsh[0];
        u.last = last[0];
        return u;
    endfunction

    // microcode: one multiply and one accumulate per entry
    function automatic t_uop ucode(logic [5:0] pc);
        t_uop u;
        unique case (pc)
            // position update with clamp
            6'd0:  u = mk(R_LM0, R_IM, SH16, 1, 1, R_POS0, 0, 1, R_POS0, SAT_CLAMP, 0, 0);
            6'd1:  u = mk(R_LM1, R_IM, SH16, 1, 1, R_POS1, 0, 1, R_POS1, SAT_CLAMP, 0, 0);
            6'd2:  u = mk(R_LM2, R_IM, SH16, 1, 1, R_POS2, 0, 1, R_POS2, SAT_CLAMP, 0, 0);
            // angular velocity
            6'd3:  u = mk(R_SM0, R_II, SH16, 0, 1, R_ZERO, 0, 1, R_T0, SAT_32, 0, 0);
            6'd4:  u = mk(R_SM1, R_II, SH16, 0, 1, R_ZERO, 0, 1, R_T1, SAT_32, 0, 0);
            6'd5:  u = mk(R_SM2, R_II, SH16, 0, 1, R_ZERO, 0, 1, R_T2, SAT_32, 0, 0);
            // quaternion update, w
            6'd6:  u = mk(R_T0, R_Q1, SH17, 0, 1, R_Q0, 1, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd7:  u = mk(R_T1, R_Q2, SH17, 0, 0, R_ZERO, 1, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd8:  u = mk(R_T2, R_Q3, SH17, 0, 0, R_ZERO, 1, 1, R_N0, SAT_SYM, 0, 0);
            // x
            6'd9:  u = mk(R_Q0, R_T0, SH17, 0, 1, R_Q1, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd10: u = mk(R_T1, R_Q3, SH17, 0, 0, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd11: u = mk(R_T2, R_Q2, SH17, 0, 0, R_ZERO, 1, 1, R_N1, SAT_SYM, 0, 0);
            // y
            6'd12: u = mk(R_Q0, R_T1, SH17, 0, 1, R_Q2, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd13: u = mk(R_T2, R_Q1, SH17, 0, 0, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd14: u = mk(R_T0, R_Q3, SH17, 0, 0, R_ZERO, 1, 1, R_N2, SAT_SYM, 0, 0);
            // z
            6'd15: u = mk(R_Q0, R_T2, SH17, 0, 1, R_Q3, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd16: u = mk(R_T0, R_Q2, SH17, 0, 0, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd17: u = mk(R_T1, R_Q1, SH17, 0, 0, R_ZERO, 1, 1, R_N3, SAT_SYM, 0, 0);
            // sum of squares
            6'd18: u = mk(R_N0, R_N0, SH0, 0, 1, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd19: u = mk(R_N1, R_N1, SH0, 0, 0, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd20: u = mk(R_N2, R_N2, SH0, 0, 0, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd21: u = mk(R_N3, R_N3, SH0, 0, 0, R_ZERO, 0, 1, R_NSQ, SAT_NONE, 0, 1);
            // force impulse
            6'd22: u = mk(R_F0, R_DT, SH16, 0, 1, R_LM0, 0, 1, R_LM0, SAT_32, 0, 0);
            6'd23: u = mk(R_F1, R_DT, SH16, 0, 1, R_LM1, 0, 1, R_LM1, SAT_32, 0, 0);
            6'd24: u = mk(R_F2, R_DT, SH16, 0, 1, R_LM2, 0, 1, R_LM2, SAT_32, 0, 1);
            // torque: exact cross product, then rounded
            6'd25: u = mk(R_A1, R_F2, SH0, 0, 1, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd26: u = mk(R_A2, R_F1, SH0, 0, 0, R_ZERO, 1, 1, R_T0, SAT_32, 1, 0);
            6'd27: u = mk(R_A2, R_F0, SH0, 0, 1, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd28: u = mk(R_A0, R_F2, SH0, 0, 0, R_ZERO, 1, 1, R_T1, SAT_32, 1, 0);
            6'd29: u = mk(R_A0, R_F1, SH0, 0, 1, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 0);
            6'd30: u = mk(R_A1, R_F0, SH0, 0, 0, R_ZERO, 1, 1, R_T2, SAT_32, 1, 0);
            6'd31: u = mk(R_T0, R_DT, SH16, 0, 1, R_SM0, 0, 1, R_SM0, SAT_32, 0, 0);
            6'd32: u = mk(R_T1, R_DT, SH16, 0, 1, R_SM1, 0, 1, R_SM1, SAT_32, 0, 0);
            6'd33: u = mk(R_T2, R_DT, SH16, 0, 1, R_SM2, 0, 1, R_SM2, SAT_32, 0, 1);
            default: u = mk(R_ZERO, R_ZERO, SH0, 0, 1, R_ZERO, 0, 0, R_ZERO, SAT_NONE, 0, 1);
        endcase
        return u;
    endfunction

    // saturate to the int32 range
    function automatic logic signed [31:0] sat32(logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fff_ffff;
        else if (v < -66'sd2147483648) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // saturate to +-(2^31-1)
    function automatic logic signed [31:0] sat_sym(logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fff_ffff;
        else if (v < -66'sd2147483647) r = 32'sh8000_0001;
        else r = v[31:0];
        return r;
    endfunction

    // magnitude, with the most negative value held at the maximum
    function automatic logic signed [31:0] abs_sat(logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == 32'sh8000_0000) r = 32'sh7fff_ffff;
        else if (v < 0) r = -v;
        else r = v;
        return r;
    endfunction

endpackage

[src/rigid_body_integrator_step.sv]
// rigid body integrator for one cube: momenta, position, orientation quaternion
// depends on rbis_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   dir  tdata / tuser
// s_axis    in   tdata: force xyz, point xyz, time_step; tuser: mode
// m_axis    out  tdata: pos xyz, quat w x y z
// cfg       in   write enable, 3-bit register index, 32-bit data
//
// one shared 33x33 multiplier with accumulator runs a microcode table, entry by entry
// step: multiply-accumulate, then square root, then division of the four quaternion components
// add force and add torque run their microcode; clears and unused modes go to the result word
// s_axis_tready is high only while idle; the result word holds until m_axis_tready
// reset is synchronous, active low, and restores box, inverses and the cube state
module rigid_body_integrator_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // force_x, force_y, force_z, point_x, point_y, point_z, time_step, pad bit
    input  logic [223:0] s_axis_tdata,
    // mode
    input  logic [2:0]   s_axis_tuser,
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    output logic [223:0] m_axis_tdata
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_ACC   = 8'b0000_0100,
        ST_SQRT  = 8'b0000_1000,
        ST_DLOAD = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_TURN  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic signed [31:0] r_blo [3];
    logic signed [31:0] r_bhi [3];
    logic [30:0]        r_im, r_ii, r_dt;
    logic signed [31:0] r_lm [3];
    logic signed [31:0] r_sm [3];
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_t [3];
    logic signed [31:0] r_nq [4];
    logic signed [31:0] r_arm [3];
    logic signed [31:0] r_f [3];
    logic [63:0]        r_nsq;
    logic signed [65:0] r_prod, r_acc;
    logic [5:0]         r_pc;
    logic               r_step;
    logic [4:0]         r_cnt;
    logic [1:0]         r_comp;
    logic [32:0]        r_srem;
    logic [31:0]        r_root;
    logic [31:0]        r_drem;
    logic [31:0]        r_dlo;

    rbis_pkg::t_uop     uop;
    logic signed [32:0] a_val, b_val, base_val;
    logic signed [65:0] term_raw, term, acc_in, n_acc, wval;
    logic signed [31:0] res32, clamp_lo, clamp_hi, sat_c;
    logic [34:0]        sq_rem2, sq_trial;
    logic               sq_ge;
    logic [31:0]        n_root;
    logic [32:0]        dv_rem2;
    logic               dv_ge;
    logic [31:0]        n_quo;
    logic [30:0]        dv_mag;
    logic [63:0]        dv_num;
    logic               in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_q[3], r_q[2], r_q[1], r_q[0], r_pos[2], r_pos[1], r_pos[0]};

    // operand select from the state and work registers
    function automatic logic signed [32:0] sel(rbis_pkg::t_reg s);
        logic signed [32:0] v;
        unique case (s)
            rbis_pkg::R_F0:   v = 33'(r_f[0]);
            rbis_pkg::R_F1:   v = 33'(r_f[1]);
            rbis_pkg::R_F2:   v = 33'(r_f[2]);
            rbis_pkg::R_A0:   v = 33'(r_arm[0]);
            rbis_pkg::R_A1:   v = 33'(r_arm[1]);
            rbis_pkg::R_A2:   v = 33'(r_arm[2]);
            rbis_pkg::R_DT:   v = $signed({2'b00, r_dt});
            rbis_pkg::R_IM:   v = $signed({2'b00, r_im});
            rbis_pkg::R_II:   v = $signed({2'b00, r_ii});
            rbis_pkg::R_LM0:  v = 33'(r_lm[0]);
            rbis_pkg::R_LM1:  v = 33'(r_lm[1]);
            rbis_pkg::R_LM2:  v = 33'(r_lm[2]);
            rbis_pkg::R_SM0:  v = 33'(r_sm[0]);
            rbis_pkg::R_SM1:  v = 33'(r_sm[1]);
            rbis_pkg::R_SM2:  v = 33'(r_sm[2]);
            rbis_pkg::R_POS0: v = 33'(r_pos[0]);
            rbis_pkg::R_POS1: v = 33'(r_pos[1]);
            rbis_pkg::R_POS2: v = 33'(r_pos[2]);
            rbis_pkg::R_Q0:   v = 33'(r_q[0]);
            rbis_pkg::R_Q1:   v = 33'(r_q[1]);
            rbis_pkg::R_Q2:   v = 33'(r_q[2]);
            rbis_pkg::R_Q3:   v = 33'(r_q[3]);
            rbis_pkg::R_T0:   v = 33'(r_t[0]);
            rbis_pkg::R_T1:   v = 33'(r_t[1]);
            rbis_pkg::R_T2:   v = 33'(r_t[2]);
            rbis_pkg::R_N0:   v = 33'(r_nq[0]);
            rbis_pkg::R_N1:   v = 33'(r_nq[1]);
            rbis_pkg::R_N2:   v = 33'(r_nq[2]);
            rbis_pkg::R_N3:   v = 33'(r_nq[3]);
            default:          v = '0;
        endcase
        return v;
    endfunction

    // multiply-accumulate datapath
    always_comb begin
        uop      = rbis_pkg::ucode(r_pc);
        a_val    = sel(uop.a);
        b_val    = sel(uop.b);
        base_val = sel(uop.base);
        unique case (uop.sh)
            rbis_pkg::SH16: term_raw = (r_prod + 66'sd32768) >>> 16;
            rbis_pkg::SH17: term_raw = (r_prod + 66'sd65536) >>> 17;
            default:        term_raw = r_prod;
        endcase
        term   = uop.tsat ? 66'(rbis_pkg::sat32(term_raw)) : term_raw;
        acc_in = uop.load ? 66'(base_val) : r_acc;
        n_acc  = uop.neg ? acc_in - term : acc_in + term;
        wval   = uop.wsh ? (n_acc + 66'sd32768) >>> 16 : n_acc;
        unique case (uop.dst)
            rbis_pkg::R_POS1: begin clamp_lo = r_blo[1]; clamp_hi = r_bhi[1]; end
            rbis_pkg::R_POS2: begin clamp_lo = r_blo[2]; clamp_hi = r_bhi[2]; end
            default:          begin clamp_lo = r_blo[0]; clamp_hi = r_bhi[0]; end
        endcase
        // upper bound first, lower bound wins when crossed
        sat_c = rbis_pkg::sat32(wval);
        if (sat_c > clamp_hi) sat_c = clamp_hi;
        if (sat_c < clamp_lo) sat_c = clamp_lo;
        unique case (uop.sat)
            rbis_pkg::SAT_SYM:   res32 = rbis_pkg::sat_sym(wval);
            rbis_pkg::SAT_CLAMP: res32 = sat_c;
            default:             res32 = rbis_pkg::sat32(wval);
        endcase
    end

    // square root digit and division bit
    always_comb begin
        sq_rem2  = {r_srem, r_nsq[63:62]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = (sq_rem2 >= sq_trial);
        n_root   = {r_root[30:0], sq_ge};
        dv_rem2  = {r_drem, r_dlo[31]};
        dv_ge    = (dv_rem2 >= {1'b0, r_root});
        n_quo    = {r_dlo[30:0], dv_ge};
        dv_mag   = r_nq[r_comp][31] ? 31'(-r_nq[r_comp]) : r_nq[r_comp][30:0];
        dv_num   = {3'b000, dv_mag, 30'd0} + {33'd0, r_root[31:1]};
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_step  <= 1'b0;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_im    <= rbis_pkg::INV_RST;
            r_ii    <= rbis_pkg::INV_RST;
            for (int i = 0; i < 3; i++) begin
                r_blo[i] <= rbis_pkg::BOX_LO_RST;
                r_bhi[i] <= rbis_pkg::BOX_HI_RST;
                r_lm[i]  <= '0;
                r_sm[i]  <= '0;
                r_pos[i] <= '0;
            end
            r_q[0] <= rbis_pkg::Q_ONE;
            r_q[1] <= '0;
            r_q[2] <= '0;
            r_q[3] <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rbis_pkg::CFG_MIN_X: r_blo[0] <= i_cfg_data;
                    rbis_pkg::CFG_MAX_X: r_bhi[0] <= i_cfg_data;
                    rbis_pkg::CFG_MIN_Y: r_blo[1] <= i_cfg_data;
                    rbis_pkg::CFG_MAX_Y: r_bhi[1] <= i_cfg_data;
                    rbis_pkg::CFG_MIN_Z: r_blo[2] <= i_cfg_data;
                    rbis_pkg::CFG_MAX_Z: r_bhi[2] <= i_cfg_data;
                    rbis_pkg::CFG_IMASS: r_im     <= i_cfg_data[30:0];
                    rbis_pkg::CFG_IINER: r_ii     <= i_cfg_data[30:0];
                endcase
            end
            unique case (r_state)
                // take a word and dispatch on mode
                ST_IDLE: begin
                    if (in_acc) begin
                        for (int i = 0; i < 3; i++) begin
                            r_f[i]   <= s_axis_tdata[32*i +: 32];
                            r_arm[i] <= rbis_pkg::sat32(66'($signed(s_axis_tdata[96+32*i +: 32]))
                                        - 66'(r_pos[i]));
                        end
                        r_dt   <= s_axis_tdata[222:192];
                        r_step <= (s_axis_tuser == rbis_pkg::MODE_STEP);
                        unique case (s_axis_tuser)
                            rbis_pkg::MODE_STEP: begin
                                r_pc <= rbis_pkg::PC_STEP;
                                r_state <= ST_MUL;
                            end
                            rbis_pkg::MODE_FORCE: begin
                                r_pc <= rbis_pkg::PC_FORCE;
                                r_state <= ST_MUL;
                            end
                            rbis_pkg::MODE_TORQUE: begin
                                r_pc <= rbis_pkg::PC_TORQUE;
                                r_state <= ST_MUL;
                            end
                            rbis_pkg::MODE_CLR_LIN: begin
                                for (int i = 0; i < 3; i++) r_lm[i] <= '0;
                                r_state <= ST_OUT;
                            end
                            rbis_pkg::MODE_CLR_ANG: begin
                                for (int i = 0; i < 3; i++) r_sm[i] <= '0;
                                r_state <= ST_OUT;
                            end
                            default: r_state <= ST_OUT;
                        endcase
                    end
                end
                // shared multiplier
                ST_MUL: begin
                    r_prod  <= a_val * b_val;
                    r_state <= ST_ACC;
                end
                // accumulate and write back
                ST_ACC: begin
                    r_acc <= n_acc;
                    if (uop.wr) begin
                        unique case (uop.dst)
                            rbis_pkg::R_LM0:  r_lm[0]  <= res32;
                            rbis_pkg::R_LM1:  r_lm[1]  <= res32;
                            rbis_pkg::R_LM2:  r_lm[2]  <= res32;
                            rbis_pkg::R_SM0:  r_sm[0]  <= res32;
                            rbis_pkg::R_SM1:  r_sm[1]  <= res32;
                            rbis_pkg::R_SM2:  r_sm[2]  <= res32;
                            rbis_pkg::R_POS0: r_pos[0] <= res32;
                            rbis_pkg::R_POS1: r_pos[1] <= res32;
                            rbis_pkg::R_POS2: r_pos[2] <= res32;
                            rbis_pkg::R_T0:   r_t[0]   <= res32;
                            rbis_pkg::R_T1:   r_t[1]   <= res32;
                            rbis_pkg::R_T2:   r_t[2]   <= res32;
                            rbis_pkg::R_N0:   r_nq[0]  <= res32;
                            rbis_pkg::R_N1:   r_nq[1]  <= res32;
                            rbis_pkg::R_N2:   r_nq[2]  <= res32;
                            rbis_pkg::R_N3:   r_nq[3]  <= res32;
                            rbis_pkg::R_NSQ:  r_nsq    <= wval[63:0];
                            default: ;
                        endcase
                    end
                    if (uop.last) begin
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= r_step ? ST_SQRT : ST_OUT;
                    end else begin
                        r_pc    <= r_pc + 6'd1;
                        r_state <= ST_MUL;
                    end
                end
                // floor square root, two bits of the radicand a cycle
                ST_SQRT: begin
                    r_srem <= sq_ge ? 33'(sq_rem2 - sq_trial) : sq_rem2[32:0];
                    r_root <= n_root;
                    r_nsq  <= {r_nsq[61:0], 2'b00};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_comp <= '0;
                        if (n_root == '0) begin
                            r_q[0]  <= rbis_pkg::Q_ONE;
                            r_q[1]  <= '0;
                            r_q[2]  <= '0;
                            r_q[3]  <= '0;
                            r_state <= ST_TURN;
                        end else begin
                            r_state <= ST_DLOAD;
                        end
                    end
                end
                // dividend of one component, rounded half away from zero
                ST_DLOAD: begin
                    r_drem  <= dv_num[63:32];
                    r_dlo   <= dv_num[31:0];
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                // restoring division, one quotient bit a cycle
                ST_DIV: begin
                    r_drem <= dv_ge ? 32'(dv_rem2 - {1'b0, r_root}) : dv_rem2[31:0];
                    r_dlo  <= n_quo;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_q[r_comp] <= r_nq[r_comp][31] ? -$signed(n_quo) : $signed(n_quo);
                        r_comp      <= r_comp + 2'd1;
                        r_state     <= (r_comp == 2'd3) ? ST_TURN : ST_DLOAD;
                    end
                end
                // momentum turned inward at the box faces
                ST_TURN: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_pos[i] <= r_blo[i]) r_lm[i] <= rbis_pkg::abs_sat(r_lm[i]);
                        else if (r_pos[i] >= r_bhi[i]) r_lm[i] <= -rbis_pkg::abs_sat(r_lm[i]);
                    end
                    r_state <= ST_OUT;
                end
                // result word waits for the sink
                ST_OUT: begin
                    if (m_axis_tready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    `ASSERT_IMPL(a_idle_no_result, s_axis_tready, !m_axis_tvalid, "result pending while idle")
    `ASSERT_CLK(a_accept_busy, in_acc |=> !s_axis_tready, "ready after accepting a word")
    `ASSERT_IMPL(a_div_nonzero, r_state == ST_DIV || r_state == ST_DLOAD, r_root != '0,
                 "division by a zero norm")
    `ASSERT_CLK(a_acc_after_mul, r_state == ST_ACC |-> $past(r_state) == ST_MUL,
                "accumulate without a product")

endmodule

[dv/tb_rigid_body_integrator_step.sv]
// testbench for rigid_body_integrator_step: random and directed words checked against a predictor
// depends on rbis_pkg and the rigid_body_integrator_step rtl
`timescale 1ns / 1ps

module tb_rigid_body_integrator_step;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // force_x, force_y, force_z, point_x, point_y, point_z, time_step, pad bit
    logic [223:0] s_axis_tdata = '0;
    // mode
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    logic [223:0] m_axis_tdata;

    rigid_body_integrator_step dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    longint box_lo[3], box_hi[3];
    longint inv_mass, inv_iner;
    int lin_mom[3], spin_mom[3], cube_pos[3], cube_quat[4];

    logic [223:0] pose_q[$];
    int  n_err = 0;
    bit  hold_rx = 1'b0;
    bit  burst_on = 1'b1;

    function automatic longint sat32_l(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint satsym_l(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483647) return -64'sd2147483647;
        return v;
    endfunction

    // round half up then floor shift
    function automatic longint rnd_shr(longint v, int s);
        v = v + (64'sd1 <<< (s - 1));
        return v >>> s;
    endfunction

    function automatic longint half_mul(longint a, longint b);
        return rnd_shr(a * b, 17);
    endfunction

    function automatic int mag_sat(int v);
        if (v == 32'sh8000_0000) return 32'sh7fff_ffff;
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic reset_model();
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = -655360; box_hi[i] = 655360;
            lin_mom[i] = 0; spin_mom[i] = 0; cube_pos[i] = 0;
        end
        inv_mass = 65536; inv_iner = 65536;
        cube_quat = '{32'sh4000_0000, 0, 0, 0};
    endtask

    function automatic void integrate_step();
        longint a, b, c, qw, qx, qy, qz, v, p;
        longint nq[4];
        longint unsigned n2, nrm, mg, r;
        for (int i = 0; i < 3; i++) begin
            v = rnd_shr(longint'(lin_mom[i]) * inv_mass, 16);
            p = sat32_l(longint'(cube_pos[i]) + sat32_l(v));
            if (p > box_hi[i]) p = box_hi[i];
            if (p < box_lo[i]) p = box_lo[i];
            cube_pos[i] = int'(p);
        end
        a = sat32_l(rnd_shr(longint'(spin_mom[0]) * inv_iner, 16));
        b = sat32_l(rnd_shr(longint'(spin_mom[1]) * inv_iner, 16));
        c = sat32_l(rnd_shr(longint'(spin_mom[2]) * inv_iner, 16));
        qw = cube_quat[0]; qx = cube_quat[1]; qy = cube_quat[2]; qz = cube_quat[3];
        nq[0] = satsym_l(qw - (half_mul(a, qx) + half_mul(b, qy) + half_mul(c, qz)));
        nq[1] = satsym_l(qx + half_mul(qw, a) + half_mul(b, qz) - half_mul(c, qy));
        nq[2] = satsym_l(qy + half_mul(qw, b) + half_mul(c, qx) - half_mul(a, qz));
        nq[3] = satsym_l(qz + half_mul(qw, c) + half_mul(a, qy) - half_mul(b, qx));
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += longint'(nq[i] * nq[i]);
        nrm = root_floor(n2);
        if (nrm == 0) begin
            cube_quat = '{32'sh4000_0000, 0, 0, 0};
        end else begin
            for (int i = 0; i < 4; i++) begin
                mg = nq[i] < 0 ? -nq[i] : nq[i];
                r = ((mg << 30) + nrm / 2) / nrm;
                cube_quat[i] = int'(sat32_l(nq[i] < 0 ? -longint'(r) : longint'(r)));
            end
        end
        // turn momentum inward at faces
        for (int i = 0; i < 3; i++) begin
            if (cube_pos[i] <= box_lo[i]) lin_mom[i] = mag_sat(lin_mom[i]);
            else if (cube_pos[i] >= box_hi[i]) lin_mom[i] = -mag_sat(lin_mom[i]);
        end
    endfunction

    function automatic logic [223:0] predict_pose(logic [2:0] mode, logic [223:0] d);
        longint f[3], pt[3], dt, r[3], tq[3];
        for (int i = 0; i < 3; i++) begin
            f[i]  = longint'($signed(d[32*i +: 32]));
            pt[i] = longint'($signed(d[96 + 32*i +: 32]));
        end
        dt = longint'(d[222:192]);
        case (mode)
            rbis_pkg::MODE_STEP: integrate_step();
            rbis_pkg::MODE_FORCE:
                for (int i = 0; i < 3; i++)
                    lin_mom[i] = int'(sat32_l(lin_mom[i] + rnd_shr(f[i] * dt, 16)));
            rbis_pkg::MODE_TORQUE: begin
                for (int i = 0; i < 3; i++) r[i] = sat32_l(pt[i] - cube_pos[i]);
                tq[0] = sat32_l(rnd_shr(r[1] * f[2] - r[2] * f[1], 16));
                tq[1] = sat32_l(rnd_shr(r[2] * f[0] - r[0] * f[2], 16));
                tq[2] = sat32_l(rnd_shr(r[0] * f[1] - r[1] * f[0], 16));
                for (int i = 0; i < 3; i++)
                    spin_mom[i] = int'(sat32_l(spin_mom[i] + rnd_shr(tq[i] * dt, 16)));
            end
            rbis_pkg::MODE_CLR_LIN: lin_mom = '{0, 0, 0};
            rbis_pkg::MODE_CLR_ANG: spin_mom = '{0, 0, 0};
            default: ;
        endcase
        return {cube_quat[3], cube_quat[2], cube_quat[1], cube_quat[0],
                cube_pos[2], cube_pos[1], cube_pos[0]};
    endfunction

    // sends one word, predicting on acceptance; valid stays up for a following word
    task automatic send_word(logic [2:0] mode, logic [223:0] d);
        if (!burst_on) begin
            s_axis_tvalid <= 1'b0;
            while (!burst_on) @(posedge i_clk);
        end
        d[223] = 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pose_q.insert(pose_q.size(), predict_pose(mode, d));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 6) begin
            if (idx[0]) box_hi[idx >> 1] = longint'($signed(val));
            else box_lo[idx >> 1] = longint'($signed(val));
        end else if (idx == rbis_pkg::CFG_IMASS) inv_mass = longint'(val[30:0]);
        else inv_iner = longint'(val[30:0]);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 200000))
                                           : -32'($urandom_range(0, 200000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [223:0] rnd_word(bit mild);
        logic [223:0] d;
        for (int i = 0; i < 6; i++)
            d[32*i +: 32] = mild ? 32'($signed($urandom_range(0, 262144)) - 131072)
                                 : rnd_val();
        d[222:192] = mild ? 31'($urandom_range(0, 131072)) : 31'(rnd_val());
        d[223] = 1'b0;
        return d;
    endfunction

    // receiver stall pattern and result check
    always @(posedge i_clk) begin
        logic [223:0] exp_w;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pose_q.size() == 0) begin
                $error("result word with no expectation");
                n_err++;
            end else begin
                exp_w = pose_q.pop_front();
                for (int k = 0; k < 7; k++)
                    if (exp_w[32*k +: 32] !== m_axis_tdata[32*k +: 32]) begin
                        $error("field %s expected %h actual %h",
                               k == 0 ? "pos_x" : k == 1 ? "pos_y" : k == 2 ? "pos_z" :
                               k == 3 ? "quat_w" : k == 4 ? "quat_x" :
                               k == 5 ? "quat_y" : "quat_z",
                               exp_w[32*k +: 32], m_axis_tdata[32*k +: 32]);
                        n_err++;
                    end
            end
        end
        if (i_rst_n) m_axis_tready <= !hold_rx && ($urandom_range(0, 3) != 0);
    end

    // sender bursts and gaps
    initial begin
        forever begin
            burst_on = 1'b1;
            repeat ($urandom_range(1, 400)) @(posedge i_clk);
            burst_on = 1'b0;
            repeat ($urandom_range(0, 30)) @(posedge i_clk);
        end
    end

    task automatic test_directed();
        logic [223:0] d;
        d = '0;
        d[31:0] = 32'h7fff_ffff; d[63:32] = 32'h8000_0000; d[95:64] = 32'h0001_0000;
        d[222:192] = 31'h7fff_ffff;
        send_word(rbis_pkg::MODE_FORCE, d);
        send_word(rbis_pkg::MODE_STEP, '0);
        send_word(rbis_pkg::MODE_STEP, '0);
        d[127:96] = 32'h8000_0000; d[159:128] = 32'h7fff_ffff; d[191:160] = 32'h0002_0000;
        send_word(rbis_pkg::MODE_TORQUE, d);
        send_word(rbis_pkg::MODE_STEP, '0);
        send_word(rbis_pkg::MODE_CLR_LIN, '1);
        send_word(rbis_pkg::MODE_CLR_ANG, '1);
        send_word(3'd5, '0);
        send_word(3'd6, '1);
        send_word(3'd7, '0);
        d = '0; d[31:0] = 32'h0010_0000; d[222:192] = 31'h0001_0000;
        send_word(rbis_pkg::MODE_FORCE, d);
        repeat (4) send_word(rbis_pkg::MODE_STEP, '0);
        // large spin: drives the quaternion toward saturation
        d = '0; d[63:32] = 32'h7fff_ffff; d[191:160] = 32'h7fff_ffff;
        d[222:192] = 31'h7fff_ffff;
        send_word(rbis_pkg::MODE_TORQUE, d);
        repeat (3) send_word(rbis_pkg::MODE_STEP, '0);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        // crossed bounds: lower wins
        write_reg(rbis_pkg::CFG_MIN_X, 32'h0010_0000);
        write_reg(rbis_pkg::CFG_MAX_X, 32'hfff0_0000);
        write_reg(rbis_pkg::CFG_MIN_Y, 32'h8000_0000);
        write_reg(rbis_pkg::CFG_MAX_Y, 32'h7fff_ffff);
        write_reg(rbis_pkg::CFG_MIN_Z, 32'h0000_0000);
        write_reg(rbis_pkg::CFG_MAX_Z, 32'h0000_0000);
        write_reg(rbis_pkg::CFG_IMASS, 32'hffff_ffff);
        write_reg(rbis_pkg::CFG_IINER, 32'h0000_0000);
        for (int i = 0; i < 12; i++)
            send_word(3'($urandom_range(0, 7)), rnd_word(0));
        wait_drained();
        write_reg(rbis_pkg::CFG_IINER, 32'h7fff_ffff);
        write_reg(rbis_pkg::CFG_IMASS, 32'h0000_0000);
        for (int i = 0; i < 12; i++)
            send_word(3'($urandom_range(0, 7)), rnd_word(0));
        wait_drained();
    endtask

    task automatic test_random(int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            if (i % 250 == 0) begin
                wait_drained();
                write_reg(rbis_pkg::CFG_MIN_X, -32'($urandom_range(0, 2000000)));
                write_reg(rbis_pkg::CFG_MAX_X, 32'($urandom_range(0, 2000000)));
                write_reg(rbis_pkg::CFG_MIN_Y, -32'($urandom_range(0, 2000000)));
                write_reg(rbis_pkg::CFG_MAX_Y, 32'($urandom_range(0, 2000000)));
                write_reg(rbis_pkg::CFG_MIN_Z, $urandom_range(0, 9) == 0 ? rnd_val()
                                               : -32'($urandom_range(0, 2000000)));
                write_reg(rbis_pkg::CFG_MAX_Z, $urandom_range(0, 9) == 0 ? rnd_val()
                                               : 32'($urandom_range(0, 2000000)));
                write_reg(rbis_pkg::CFG_IMASS, $urandom_range(0, 9) == 0 ? $urandom
                                               : $urandom_range(0, 200000));
                write_reg(rbis_pkg::CFG_IINER, $urandom_range(0, 9) == 0 ? $urandom
                                               : $urandom_range(0, 200000));
            end
            kind = $urandom_range(0, 19);
            if (kind < 8) send_word(rbis_pkg::MODE_STEP, rnd_word(1));
            else if (kind < 11) send_word(rbis_pkg::MODE_FORCE, rnd_word(kind != 10));
            else if (kind < 14) send_word(rbis_pkg::MODE_TORQUE, rnd_word(kind != 13));
            else if (kind < 16) send_word(rbis_pkg::MODE_CLR_LIN, rnd_word(0));
            else if (kind < 18) send_word(rbis_pkg::MODE_CLR_ANG, rnd_word(0));
            else send_word(3'($urandom_range(5, 7)), rnd_word(0));
        end
    endtask

    // receiver held off while the sender keeps offering words
    task automatic test_backpressure();
        hold_rx = 1'b1;
        fork
            begin
                repeat (2000) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 8; i++) send_word(3'($urandom_range(0, 4)), rnd_word(1));
        join
        wait_drained();
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random(1500);
        wait_drained();
        if (n_err == 0) $display("tb_rigid_body_integrator_step: clean");
        else $display("tb_rigid_body_integrator_step: errors");
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_rigid_body_integrator_step: errors");
        $finish;
    end

endmodule
